/* design/vqdm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vqdm_pkg
// Shared types and codes for the virtqueue descriptor manager.
// ----------------------------------------------------------------------------
package vqdm_pkg;

    localparam logic [1:0] KIND_SUBMIT   = 2'd0;
    localparam logic [1:0] KIND_COMPLETE = 2'd1;
    localparam logic [1:0] KIND_READ     = 2'd2;
    localparam logic [1:0] KIND_NONE     = 2'd3;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_REFUSED = 2'd1;
    localparam logic [1:0] STAT_BAD_ID  = 2'd2;
    localparam logic [1:0] STAT_CORRUPT = 2'd3;

    localparam logic [15:0] NO_LINK   = 16'hFFFF;
    localparam int          FLAG_NEXT = 0;

    typedef struct packed {
        logic [63:0] addr;
        logic [31:0] len;
        logic [15:0] flags;
        logic [15:0] link;
    } desc_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SUB_RD,
        ST_SUB_WR,
        ST_CMP_RD,
        ST_CMP_WR,
        ST_RD_RD,
        ST_RD_OUT
    } state_t;

endpackage
`default_nettype wire

/* design/virtqueue_descriptor_manager_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// virtqueue_descriptor_manager_top
// Split virtqueue descriptor table with a linked free list in one RAM.
// ----------------------------------------------------------------------------
// Refused submits and bad completion ids: result in the cycle after start.
// Submit and read: RAM read, then write back / output, then the registered result.
// Completion: a RAM read and a write back per descriptor walked, ending on a corrupt link.
// One item at a time; busy is high while an item is at work.
// Reset and each queue_size write run a clear of all MAX_QUEUE_SIZE table entries,
// busy high throughout. The result strobe cannot be stalled.
module virtqueue_descriptor_manager_top #(
    parameter int MAX_QUEUE_SIZE = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  kind,
    input  wire logic [63:0] buf_addr,
    input  wire logic [31:0] buf_len,
    input  wire logic [15:0] buf_flags,
    input  wire logic [8:0]  chain_count,
    input  wire logic [15:0] used_id,
    input  wire logic [31:0] used_len,
    input  wire logic [7:0]  read_index,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [8:0]  cfg_data,
    output logic             result_valid,
    output logic [1:0]       status,
    output logic [7:0]       desc_index,
    output logic [7:0]       head_index,
    output logic [7:0]       avail_slot,
    output logic             chain_done,
    output logic [31:0]      done_len,
    output logic [63:0]      rd_addr,
    output logic [31:0]      rd_len,
    output logic [15:0]      rd_flags,
    output logic [15:0]      rd_next,
    output logic [8:0]       free_count
);
    import vqdm_pkg::*;

    localparam int IDX_W = $clog2(MAX_QUEUE_SIZE);
    localparam int QS_W  = $clog2(MAX_QUEUE_SIZE + 1);
    localparam int QS_RESET = (MAX_QUEUE_SIZE < 256) ? MAX_QUEUE_SIZE : 256;

    desc_t mem [MAX_QUEUE_SIZE];
    desc_t rdata_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    desc_t            mem_wdata;
    logic             mem_re;

    state_t           state_reg, state_next;
    logic [QS_W-1:0]  qs_reg, qs_next;
    logic [15:0]      list_head_reg, list_head_next;
    logic [QS_W-1:0]  free_total_reg, free_total_next;
    logic [15:0]      avail_reg, avail_next;
    logic [QS_W-1:0]  slot_reg, slot_next;
    logic [8:0]       seg_left_reg, seg_left_next;
    logic [15:0]      open_head_reg, open_head_next;
    logic             refused_reg, refused_next;
    logic [IDX_W-1:0] clr_reg, clr_next;
    logic             first_reg, first_next;
    logic             last_reg, last_next;
    logic             res_valid_reg, res_valid_next;

    logic [15:0]      walk_reg, walk_next;
    logic [63:0]      addr_reg, addr_next;
    logic [31:0]      len_reg, len_next;
    logic [15:0]      flags_reg, flags_next;
    logic [31:0]      ulen_reg, ulen_next;
    logic             rd_ok_reg, rd_ok_next;

    // completion head id, held for the whole walk
    logic [7:0]       head_id_reg;

    logic [1:0]  res_status_reg, e_status;
    logic [7:0]  res_desc_reg, e_desc;
    logic [7:0]  res_head_reg, e_head;
    logic [7:0]  res_slot_reg, e_slot;
    logic        res_done_reg, e_done;
    logic [31:0] res_dlen_reg, e_dlen;
    logic [63:0] res_raddr_reg, e_raddr;
    logic [31:0] res_rlen_reg, e_rlen;
    logic [15:0] res_rflags_reg, e_rflags;
    logic [15:0] res_rnext_reg, e_rnext;
    logic [8:0]  res_free_reg;
    logic        emit;

    logic [8:0]       cfg_clamped;
    logic             accept;
    logic [8:0]       seg_eff;
    logic [15:0]      clr_link;
    logic [IDX_W-1:0] walk_idx;

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign walk_idx  = walk_reg[IDX_W-1:0];

    always_comb
    begin
        cfg_clamped = cfg_data;
        if (cfg_data == 9'd0)
        begin
            cfg_clamped = 9'd1;
        end
        else if (32'(cfg_data) > MAX_QUEUE_SIZE)
        begin
            cfg_clamped = 9'(MAX_QUEUE_SIZE);
        end
    end

    always_comb
    begin
        if (32'(clr_reg) + 32'd1 < 32'(qs_reg))
        begin
            clr_link = 16'(32'(clr_reg) + 32'd1);
        end
        else
        begin
            clr_link = NO_LINK;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        qs_next         = qs_reg;
        list_head_next  = list_head_reg;
        free_total_next = free_total_reg;
        avail_next      = avail_reg;
        slot_next       = slot_reg;
        seg_left_next   = seg_left_reg;
        open_head_next  = open_head_reg;
        refused_next    = refused_reg;
        clr_next        = clr_reg;
        first_next      = first_reg;
        last_next       = last_reg;
        walk_next       = walk_reg;
        addr_next       = addr_reg;
        len_next        = len_reg;
        flags_next      = flags_reg;
        ulen_next       = ulen_reg;
        rd_ok_next      = rd_ok_reg;
        seg_eff         = 9'd0;

        mem_we    = 1'b0;
        mem_waddr = walk_idx;
        mem_wdata = '0;
        mem_re    = 1'b0;

        emit     = 1'b0;
        e_status = STAT_OK;
        e_desc   = 8'd0;
        e_head   = 8'd0;
        e_slot   = 8'd0;
        e_done   = 1'b0;
        e_dlen   = 32'd0;
        e_raddr  = 64'd0;
        e_rlen   = 32'd0;
        e_rflags = 16'd0;
        e_rnext  = 16'd0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    addr_next  = buf_addr;
                    len_next   = buf_len;
                    flags_next = buf_flags;
                    ulen_next  = used_len;
                    case (kind)
                        KIND_SUBMIT:
                        begin
                            if (seg_left_reg == 9'd0)
                            begin
                                refused_next = 1'b0;
                                if (chain_count == 9'd0 ||
                                    32'(chain_count) > 32'(free_total_reg))
                                begin
                                    if (chain_count != 9'd0)
                                    begin
                                        seg_left_next = chain_count - 9'd1;
                                        refused_next  = (chain_count != 9'd1);
                                    end
                                    emit     = 1'b1;
                                    e_status = STAT_REFUSED;
                                end
                                else
                                begin
                                    seg_eff = chain_count;
                                end
                            end
                            else if (refused_reg)
                            begin
                                seg_left_next = seg_left_reg - 9'd1;
                                refused_next  = (seg_left_reg != 9'd1);
                                emit     = 1'b1;
                                e_status = STAT_REFUSED;
                            end
                            else
                            begin
                                seg_eff = seg_left_reg;
                            end

                            if (!emit)
                            begin
                                if (free_total_reg == '0 ||
                                    32'(list_head_reg) >= 32'(qs_reg))
                                begin
                                    // free list unusable: drop rest of chain
                                    seg_left_next = 9'd0;
                                    refused_next  = 1'b0;
                                    emit     = 1'b1;
                                    e_status = STAT_REFUSED;
                                end
                                else
                                begin
                                    first_next    = (seg_left_reg == 9'd0);
                                    seg_left_next = seg_eff - 9'd1;
                                    last_next     = (seg_eff == 9'd1);
                                    walk_next     = list_head_reg;
                                    state_next    = ST_SUB_RD;
                                end
                            end
                        end
                        KIND_COMPLETE:
                        begin
                            walk_next = used_id;
                            if (32'(used_id) >= 32'(qs_reg))
                            begin
                                emit     = 1'b1;
                                e_status = STAT_BAD_ID;
                                e_head   = used_id[7:0];
                            end
                            else
                            begin
                                state_next = ST_CMP_RD;
                            end
                        end
                        KIND_READ:
                        begin
                            walk_next  = 16'(read_index);
                            rd_ok_next = (32'(read_index) < MAX_QUEUE_SIZE);
                            state_next = ST_RD_RD;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '{addr: 64'd0, len: 32'd0, flags: 16'd0, link: clr_link};
                clr_next  = clr_reg + 1'b1;
                if (32'(clr_reg) == MAX_QUEUE_SIZE - 1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SUB_RD:
            begin
                mem_re     = 1'b1;
                state_next = ST_SUB_WR;
            end
            ST_SUB_WR:
            begin
                list_head_next  = rdata_reg.link;
                free_total_next = free_total_reg - 1'b1;
                if (first_reg)
                begin
                    open_head_next = walk_reg;
                end
                mem_we          = 1'b1;
                mem_wdata.addr  = addr_reg;
                mem_wdata.len   = len_reg;
                mem_wdata.flags = flags_reg;
                mem_wdata.flags[FLAG_NEXT] = !last_reg;
                mem_wdata.link  = last_reg ? 16'd0 : rdata_reg.link;
                emit   = 1'b1;
                e_desc = walk_reg[7:0];
                e_head = first_reg ? walk_reg[7:0] : open_head_reg[7:0];
                if (last_reg)
                begin
                    e_slot     = 8'(slot_reg);
                    e_done     = 1'b1;
                    avail_next = avail_reg + 16'd1;
                    if (avail_reg == 16'hFFFF ||
                        32'(slot_reg) + 32'd1 == 32'(qs_reg))
                    begin
                        slot_next = '0;
                    end
                    else
                    begin
                        slot_next = slot_reg + 1'b1;
                    end
                end
                state_next = ST_IDLE;
            end
            ST_CMP_RD:
            begin
                if (32'(walk_reg) >= 32'(qs_reg))
                begin
                    // corrupt link: leak the rest
                    emit       = 1'b1;
                    e_status   = STAT_CORRUPT;
                    e_done     = 1'b1;
                    e_dlen     = ulen_reg;
                    state_next = ST_IDLE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = ST_CMP_WR;
                end
            end
            ST_CMP_WR:
            begin
                mem_we         = 1'b1;
                mem_wdata.link = list_head_reg;
                list_head_next = walk_reg;
                if (free_total_reg < qs_reg)
                begin
                    free_total_next = free_total_reg + 1'b1;
                end
                if (!rdata_reg.flags[FLAG_NEXT])
                begin
                    emit       = 1'b1;
                    e_done     = 1'b1;
                    e_dlen     = ulen_reg;
                    state_next = ST_IDLE;
                end
                else
                begin
                    walk_next  = rdata_reg.link;
                    state_next = ST_CMP_RD;
                end
            end
            ST_RD_RD:
            begin
                mem_re     = 1'b1;
                state_next = ST_RD_OUT;
            end
            ST_RD_OUT:
            begin
                emit = 1'b1;
                if (rd_ok_reg)
                begin
                    e_raddr  = rdata_reg.addr;
                    e_rlen   = rdata_reg.len;
                    e_rflags = rdata_reg.flags;
                    e_rnext  = rdata_reg.link;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // head index of completions comes from the walk's start id
        if (state_reg == ST_CMP_RD || state_reg == ST_CMP_WR)
        begin
            e_head = head_id_reg;
        end

        // size write: rebuild everything and sweep the table
        if (cfg_valid)
        begin
            qs_next         = QS_W'(cfg_clamped);
            list_head_next  = 16'd0;
            free_total_next = QS_W'(cfg_clamped);
            avail_next      = 16'd0;
            slot_next       = '0;
            seg_left_next   = 9'd0;
            open_head_next  = 16'd0;
            refused_next    = 1'b0;
            clr_next        = '0;
            emit            = 1'b0;
            mem_we          = 1'b0;
            state_next      = ST_CLEAR;
        end

        res_valid_next = emit;
    end

    always_ff @(posedge clk)
    begin
        if (accept && kind == KIND_COMPLETE)
        begin
            head_id_reg <= used_id[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            qs_reg         <= QS_W'(QS_RESET);
            list_head_reg  <= 16'd0;
            free_total_reg <= QS_W'(QS_RESET);
            avail_reg      <= 16'd0;
            slot_reg       <= '0;
            seg_left_reg   <= 9'd0;
            open_head_reg  <= 16'd0;
            refused_reg    <= 1'b0;
            clr_reg        <= '0;
            first_reg      <= 1'b0;
            last_reg       <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            qs_reg         <= qs_next;
            list_head_reg  <= list_head_next;
            free_total_reg <= free_total_next;
            avail_reg      <= avail_next;
            slot_reg       <= slot_next;
            seg_left_reg   <= seg_left_next;
            open_head_reg  <= open_head_next;
            refused_reg    <= refused_next;
            clr_reg        <= clr_next;
            first_reg      <= first_next;
            last_reg       <= last_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        walk_reg  <= walk_next;
        addr_reg  <= addr_next;
        len_reg   <= len_next;
        flags_reg <= flags_next;
        ulen_reg  <= ulen_next;
        rd_ok_reg <= rd_ok_next;
        if (emit)
        begin
            res_status_reg <= e_status;
            res_desc_reg   <= e_desc;
            res_head_reg   <= e_head;
            res_slot_reg   <= e_slot;
            res_done_reg   <= e_done;
            res_dlen_reg   <= e_dlen;
            res_raddr_reg  <= e_raddr;
            res_rlen_reg   <= e_rlen;
            res_rflags_reg <= e_rflags;
            res_rnext_reg  <= e_rnext;
            res_free_reg   <= 9'(free_total_next);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[walk_idx];
        end
    end

    assign result_valid = res_valid_reg;
    assign status       = res_status_reg;
    assign desc_index   = res_desc_reg;
    assign head_index   = res_head_reg;
    assign avail_slot   = res_slot_reg;
    assign chain_done   = res_done_reg;
    assign done_len     = res_dlen_reg;
    assign rd_addr      = res_raddr_reg;
    assign rd_len       = res_rlen_reg;
    assign rd_flags     = res_rflags_reg;
    assign rd_next      = res_rnext_reg;
    assign free_count   = res_free_reg;

endmodule
`default_nettype wire

/* design/vqdm_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vqdm_checker
// Port-level checks for the virtqueue descriptor manager.
// ----------------------------------------------------------------------------
module vqdm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic [1:0]  kind,
    input wire logic        cfg_valid,
    input wire logic        result_valid,
    input wire logic [1:0]  status,
    input wire logic [7:0]  avail_slot,
    input wire logic        chain_done,
    input wire logic [31:0] done_len
);
    import vqdm_pkg::*;

    // every accepted item other than KIND_NONE either starts work or answers next cycle
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind != KIND_NONE && !cfg_valid) |=> (busy || result_valid))
        else $error("accepted item made no progress");

    // a result beat only appears once the block is free again
    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result while busy");

    a_bad_id: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status == STAT_BAD_ID) |-> (!chain_done && done_len == 32'd0))
        else $error("bad completion id carried chain_done or length");

    a_slot_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && avail_slot != 8'd0) |-> (chain_done && status == STAT_OK))
        else $error("avail slot on a non-published result");

endmodule

bind virtqueue_descriptor_manager_top vqdm_checker u_vqdm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .cfg_valid    (cfg_valid),
    .result_valid (result_valid),
    .status       (status),
    .avail_slot   (avail_slot),
    .chain_done   (chain_done),
    .done_len     (done_len)
);
`default_nettype wire

/* tb/sv/vqdm_scoreboard.sv */
// ----------------------------------------------------------------------------
// vqdm_scoreboard
// Watches the item, size-write and result channels of the descriptor manager,
// keeps its own copy of the descriptor table and free list, and checks each
// result against the oldest predicted one.
// ----------------------------------------------------------------------------
module vqdm_scoreboard #(
    parameter int MAX_QUEUE_SIZE = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  kind,
    input  logic [63:0] buf_addr,
    input  logic [31:0] buf_len,
    input  logic [15:0] buf_flags,
    input  logic [8:0]  chain_count,
    input  logic [15:0] used_id,
    input  logic [31:0] used_len,
    input  logic [7:0]  read_index,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [8:0]  cfg_data,
    input  logic        result_valid,
    input  logic [1:0]  status,
    input  logic [7:0]  desc_index,
    input  logic [7:0]  head_index,
    input  logic [7:0]  avail_slot,
    input  logic        chain_done,
    input  logic [31:0] done_len,
    input  logic [63:0] rd_addr,
    input  logic [31:0] rd_len,
    input  logic [15:0] rd_flags,
    input  logic [15:0] rd_next,
    input  logic [8:0]  free_count,
    output int          fail_count,
    output int          pending
);
    import vqdm_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  desc_index;
        logic [7:0]  head_index;
        logic [7:0]  avail_slot;
        logic        chain_done;
        logic [31:0] done_len;
        logic [63:0] rd_addr;
        logic [31:0] rd_len;
        logic [15:0] rd_flags;
        logic [15:0] rd_next;
        logic [8:0]  free_count;
    } answer_t;

    answer_t     answers_due[$];

    logic [63:0] tbl_addr [MAX_QUEUE_SIZE];
    logic [31:0] tbl_len  [MAX_QUEUE_SIZE];
    logic [15:0] tbl_flags[MAX_QUEUE_SIZE];
    logic [15:0] tbl_link [MAX_QUEUE_SIZE];
    int          qsize;
    int          list_head;
    int          free_total;
    logic [15:0] avail_cnt;
    logic [15:0] used_cnt;
    int          seg_left;
    int          chain_head;
    bit          dropping;
    int          mismatches;

    assign fail_count = mismatches;
    assign pending    = answers_due.size();

    task automatic rebuild_table();
        for (int i = 0; i < MAX_QUEUE_SIZE; i++)
        begin
            tbl_addr[i]  = '0;
            tbl_len[i]   = '0;
            tbl_flags[i] = '0;
            tbl_link[i]  = (i + 1 < qsize) ? 16'(i + 1) : NO_LINK;
        end
        list_head  = 0;
        free_total = qsize;
        avail_cnt  = '0;
        used_cnt   = '0;
        seg_left   = 0;
        chain_head = 0;
        dropping   = 0;
    endtask

    function automatic answer_t blank_answer(logic [1:0] st);
        answer_t a;
        a = '0;
        a.status = st;
        return a;
    endfunction

    task automatic take_segment(output answer_t a);
        bit   first;
        int   n;
        int   idx;
        first = (seg_left == 0);
        if (first)
        begin
            n = chain_count;
            dropping = 0;
            if (n == 0 || n > free_total)
            begin
                if (n > 0)
                begin
                    seg_left = n - 1;
                    dropping = (seg_left != 0);
                end
                a = blank_answer(STAT_REFUSED);
                a.free_count = 9'(free_total);
                return;
            end
            seg_left = n;
        end
        else if (dropping)
        begin
            seg_left--;
            if (seg_left == 0)
                dropping = 0;
            a = blank_answer(STAT_REFUSED);
            a.free_count = 9'(free_total);
            return;
        end
        // free list ran dry or points off the table mid-chain: drop the rest
        if (free_total == 0 || list_head >= qsize)
        begin
            seg_left = 0;
            dropping = 0;
            a = blank_answer(STAT_REFUSED);
            a.free_count = 9'(free_total);
            return;
        end
        idx = list_head;
        list_head = tbl_link[idx];
        free_total--;
        if (first)
            chain_head = idx;
        seg_left--;
        tbl_addr[idx] = buf_addr;
        tbl_len[idx]  = buf_len;
        a = blank_answer(STAT_OK);
        a.desc_index = 8'(idx);
        a.head_index = 8'(chain_head);
        if (seg_left == 0)
        begin
            tbl_flags[idx] = buf_flags & ~(16'd1 << FLAG_NEXT);
            tbl_link[idx]  = '0;
            a.avail_slot   = 8'(int'(avail_cnt) % qsize);
            a.chain_done   = 1'b1;
            avail_cnt++;
        end
        else
        begin
            tbl_flags[idx] = buf_flags | (16'd1 << FLAG_NEXT);
            tbl_link[idx]  = 16'(list_head);
        end
        a.free_count = 9'(free_total);
    endtask

    task automatic retire_chain(output answer_t a);
        int          idx;
        logic [15:0] fl;
        logic [15:0] nx;
        logic [1:0]  st;
        used_cnt++;
        a = '0;
        a.head_index = used_id[7:0];
        if (used_id >= qsize)
        begin
            a.status     = STAT_BAD_ID;
            a.free_count = 9'(free_total);
            return;
        end
        idx = used_id;
        st  = STAT_OK;
        for (int steps = 0; steps <= MAX_QUEUE_SIZE; steps++)
        begin
            if (idx >= qsize)
            begin
                st = STAT_CORRUPT;
                break;
            end
            fl = tbl_flags[idx];
            nx = tbl_link[idx];
            tbl_addr[idx]  = '0;
            tbl_len[idx]   = '0;
            tbl_flags[idx] = '0;
            tbl_link[idx]  = 16'(list_head);
            list_head = idx;
            if (free_total < qsize)
                free_total++;
            if (!fl[FLAG_NEXT])
                break;
            idx = nx;
        end
        a.status     = st;
        a.chain_done = 1'b1;
        a.done_len   = used_len;
        a.free_count = 9'(free_total);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        answer_t a;
        answer_t got;
        int      v;
        if (!rst_n)
        begin
            qsize = (MAX_QUEUE_SIZE < 256) ? MAX_QUEUE_SIZE : 256;
            rebuild_table();
            answers_due.delete();
            mismatches = 0;
        end
        else
        begin
            if (result_valid)
            begin
                got = '{status, desc_index, head_index, avail_slot, chain_done, done_len,
                        rd_addr, rd_len, rd_flags, rd_next, free_count};
                if (answers_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h", got);
                end
                else
                begin
                    a = answers_due.pop_front();
                    if (got !== a)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch at %0t: expected %h got %h", $realtime, a, got);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                v = cfg_data;
                if (v < 1)
                    v = 1;
                if (v > MAX_QUEUE_SIZE)
                    v = MAX_QUEUE_SIZE;
                qsize = v;
                rebuild_table();
            end
            if (start && !busy)
            begin
                case (kind)
                    KIND_SUBMIT:
                    begin
                        take_segment(a);
                        answers_due.push_back(a);
                    end
                    KIND_COMPLETE:
                    begin
                        retire_chain(a);
                        answers_due.push_back(a);
                    end
                    KIND_READ:
                    begin
                        a = blank_answer(STAT_OK);
                        if (int'(read_index) < MAX_QUEUE_SIZE)
                        begin
                            a.rd_addr  = tbl_addr[read_index];
                            a.rd_len   = tbl_len[read_index];
                            a.rd_flags = tbl_flags[read_index];
                            a.rd_next  = tbl_link[read_index];
                        end
                        a.free_count = 9'(free_total);
                        answers_due.push_back(a);
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

endmodule

/* tb/sv/virtqueue_descriptor_manager_top_test.sv */
// ----------------------------------------------------------------------------
// virtqueue_descriptor_manager_top_test
// Drives submit chains, completions and descriptor reads into the manager
// under several queue sizes and sender gap patterns; the scoreboard checks.
// ----------------------------------------------------------------------------
module virtqueue_descriptor_manager_top_test;
    import vqdm_pkg::*;

    localparam int QMAX        = 256;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int N_ITEMS     = 450;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  kind = KIND_NONE;
    logic [63:0] buf_addr = '0;
    logic [31:0] buf_len = '0;
    logic [15:0] buf_flags = '0;
    logic [8:0]  chain_count = '0;
    logic [15:0] used_id = '0;
    logic [31:0] used_len = '0;
    logic [7:0]  read_index = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [8:0]  cfg_data = '0;
    logic        result_valid;
    logic [1:0]  status;
    logic [7:0]  desc_index;
    logic [7:0]  head_index;
    logic [7:0]  avail_slot;
    logic        chain_done;
    logic [31:0] done_len;
    logic [63:0] rd_addr;
    logic [31:0] rd_len;
    logic [15:0] rd_flags;
    logic [15:0] rd_next;
    logic [8:0]  free_count;
    int          fail_count;
    int          pending;

    int          cycles = 0;
    int          items_sent = 0;
    int          size_writes = 0;
    int          gap_pct = 0;
    logic [1:0]  kinds_sent[$];
    logic [7:0]  live_heads[$];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    virtqueue_descriptor_manager_top #(.MAX_QUEUE_SIZE(QMAX)) u_dut (.*);

    vqdm_scoreboard #(.MAX_QUEUE_SIZE(QMAX)) u_scoreboard (.*);

    // harvest published heads so completions can hand back real chains
    always @(posedge clk)
    begin
        logic [1:0] k;
        if (result_valid && kinds_sent.size() > 0)
        begin
            k = kinds_sent.pop_front();
            if (k == KIND_SUBMIT && status == STAT_OK && chain_done)
                live_heads.push_back(head_index);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL virtqueue_descriptor_manager_top");
            $finish;
        end
    end

    task automatic send(logic [1:0] k, logic [63:0] a, logic [31:0] l, logic [15:0] f,
                        logic [8:0] n, logic [15:0] uid, logic [31:0] ulen, logic [7:0] ri);
        kind        <= k;
        buf_addr    <= a;
        buf_len     <= l;
        buf_flags   <= f;
        chain_count <= n;
        used_id     <= uid;
        used_len    <= ulen;
        read_index  <= ri;
        start       <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        if (k != KIND_NONE)
            kinds_sent.push_back(k);
        items_sent++;
        if ($urandom_range(0, 99) < gap_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic submit(logic [8:0] n);
        send(KIND_SUBMIT, {$urandom, $urandom}, $urandom, 16'($urandom), n,
             16'($urandom), $urandom, 8'($urandom));
    endtask

    task automatic complete(logic [15:0] uid);
        send(KIND_COMPLETE, {$urandom, $urandom}, $urandom, 16'($urandom), 9'($urandom),
             uid, $urandom, 8'($urandom));
    endtask

    task automatic read_back(logic [7:0] ri);
        send(KIND_READ, {$urandom, $urandom}, $urandom, 16'($urandom), 9'($urandom),
             16'($urandom), $urandom, ri);
    endtask

    task automatic write_size(logic [8:0] v);
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        // a dropped kind-3 item leaves no result behind; let it drain
        repeat (8) @(posedge clk);
        while (busy)
            @(posedge clk);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        size_writes++;
        live_heads.delete();
    endtask

    task automatic random_item(int qs);
        int r;
        int n;
        int pick;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            n = $urandom_range(1, 4);
            submit(9'(n));
            for (int s = 1; s < n; s++)
                submit(9'($urandom));
        end
        else if (r < 80)
        begin
            if (live_heads.size() > 0)
            begin
                pick = $urandom_range(0, live_heads.size() - 1);
                complete(16'(live_heads[pick]));
                live_heads.delete(pick);
            end
            else
                complete(16'($urandom_range(0, qs - 1)));
        end
        else if (r < 92)
            read_back(8'($urandom));
        else if (r < 94)
            submit(9'($urandom));
        else if (r < 97)
            complete(16'($urandom));
        else
            send(KIND_NONE, {$urandom, $urandom}, $urandom, 16'($urandom), 9'($urandom),
                 16'($urandom), $urandom, 8'($urandom));
    endtask

    initial
    begin
        int sizes[4];
        int clamped;
        sizes = '{8, 256, 3, 64};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes at full size
        submit(9'd0);
        send(KIND_SUBMIT, '1, '1, '1, 9'd1, '0, '0, '0);
        send(KIND_SUBMIT, '0, '0, '0, 9'd3, '1, '1, '1);
        send(KIND_SUBMIT, '1, '1, '1, 9'd0, '0, '0, '0);
        send(KIND_SUBMIT, '0, '0, '1, 9'd0, '0, '0, '0);
        read_back(8'd0);
        read_back(8'd1);
        read_back(8'd255);
        send(KIND_COMPLETE, '0, '0, '0, '0, 16'd1, '1, '0);
        send(KIND_COMPLETE, '0, '0, '0, '0, 16'hFFFF, '1, '0);
        send(KIND_COMPLETE, '0, '0, '0, '0, 16'd256, '0, '0);
        send(KIND_NONE, '1, '1, '1, '1, '1, '1, '1);
        complete(16'd0);
        read_back(8'd0);
        // completing a descriptor already on the free list pushes it once more
        complete(16'd200);

        // directed: tiny queue, refusals, exhaustion
        write_size(9'd2);
        submit(9'd3);
        submit(9'd1);
        submit(9'd1);
        submit(9'd2);
        submit(9'd1);
        complete(16'd0);
        complete(16'd2);
        read_back(8'd1);
        write_size(9'd0);
        submit(9'd1);
        submit(9'd1);
        write_size(9'h1FF);

        for (int p = 0; p < 4; p++)
        begin
            write_size(9'(sizes[p]));
            clamped = sizes[p];
            while (items_sent < 30 + (p + 1) * N_ITEMS / 4)
            begin
                if (items_sent < 30 + N_ITEMS / 3)
                    gap_pct = 8;
                else if (items_sent < 30 + 2 * N_ITEMS / 3)
                    gap_pct = 79;
                else
                    gap_pct = 0;
                random_item(clamped);
            end
        end

        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);

        $display("sent %0d items over %0d queue size writes, %0d mismatches",
                 items_sent, size_writes, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("PASS virtqueue_descriptor_manager_top");
        else
            $display("FAIL virtqueue_descriptor_manager_top");
        $finish;
    end

endmodule
